>>> design/arp_pkg.sv
// Package for the ARP header parser: request and response payload types,
// header layout constants and status/segment codes. No dependencies.
`timescale 1ns / 1ps

package arp_pkg;

   // Fixed header length in bytes and the widths of the position counter.
   localparam int unsigned HDR_LEN   = 8;
   localparam int unsigned COUNT_W   = 11;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Largest address length that is accepted.
   localparam logic [7:0] MAX_ADDR_LEN = 8'd16;

   // Header byte positions.
   localparam logic [2:0] POS_HW_CODE_HI    = 3'd0;
   localparam logic [2:0] POS_HW_CODE_LO    = 3'd1;
   localparam logic [2:0] POS_PROTO_CODE_HI = 3'd2;
   localparam logic [2:0] POS_PROTO_CODE_LO = 3'd3;
   localparam logic [2:0] POS_HW_LEN        = 3'd4;
   localparam logic [2:0] POS_PROTO_LEN     = 3'd5;
   localparam logic [2:0] POS_OPCODE_HI     = 3'd6;
   localparam logic [2:0] POS_OPCODE_LO     = 3'd7;

   // Response kinds.
   localparam logic KIND_ADDR    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // Address segments.
   localparam logic [1:0] SEG_SENDER_HW    = 2'd0;
   localparam logic [1:0] SEG_SENDER_PROTO = 2'd1;
   localparam logic [1:0] SEG_TARGET_HW    = 2'd2;
   localparam logic [1:0] SEG_TARGET_PROTO = 2'd3;

   // Summary status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
   localparam logic [1:0] STATUS_BAD_LEN   = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } arp_req_type;

   typedef struct packed {
      logic        kind;
      logic [1:0]  segment;
      logic [3:0]  byte_index;
      logic [7:0]  byte_value;
      logic [15:0] hw_code;
      logic [15:0] proto_code;
      logic [7:0]  hw_length;
      logic [7:0]  proto_length;
      logic [15:0] op_code;
      logic [1:0]  status;
   } arp_rsp_type;

   // Which responses the request in the input register produces.
   typedef struct packed {
      logic addr;
      logic summary;
   } arp_emit_type;

endpackage

>>> design/arp_field_decode.sv
// Header tracking and field decode for the ARP parser: byte counter, latched
// header fields, address segment classification and the end-of-packet status.
// Depends on arp_pkg.
`timescale 1ns / 1ps

module arp_field_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  arp_pkg::arp_req_type item,
   input  logic                 commit,
   output arp_pkg::arp_emit_type emit,
   output arp_pkg::arp_rsp_type addr_rsp,
   output arp_pkg::arp_rsp_type sum_rsp
);
   import arp_pkg::*;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [15:0] hw_code_ff, hw_code_in, hw_code_upd;
   logic [15:0] proto_code_ff, proto_code_in, proto_code_upd;
   logic [7:0]  hw_len_ff, hw_len_in, hw_len_upd;
   logic [7:0]  proto_len_ff, proto_len_in, proto_len_upd;
   logic [15:0] opcode_ff, opcode_in, opcode_upd;

   logic               in_header;
   logic               len_ok;
   logic [COUNT_W-1:0] off, h, p, b2, b3, b4, idx_full;
   logic [1:0]         seg;
   logic               in_addr;
   logic [COUNT_W:0]   total;
   logic [1:0]         status;

   assign in_header = (count_ff < COUNT_W'(HDR_LEN));

   // Header bytes overwrite their register as they pass.
   always_comb begin
      hw_code_upd    = hw_code_ff;
      proto_code_upd = proto_code_ff;
      hw_len_upd     = hw_len_ff;
      proto_len_upd  = proto_len_ff;
      opcode_upd     = opcode_ff;
      if (in_header) begin
         unique case (count_ff[2:0])
            POS_HW_CODE_HI:    hw_code_upd[15:8]    = item.data_byte;
            POS_HW_CODE_LO:    hw_code_upd[7:0]     = item.data_byte;
            POS_PROTO_CODE_HI: proto_code_upd[15:8] = item.data_byte;
            POS_PROTO_CODE_LO: proto_code_upd[7:0]  = item.data_byte;
            POS_HW_LEN:        hw_len_upd           = item.data_byte;
            POS_PROTO_LEN:     proto_len_upd        = item.data_byte;
            POS_OPCODE_HI:     opcode_upd[15:8]     = item.data_byte;
            POS_OPCODE_LO:     opcode_upd[7:0]      = item.data_byte;
            default:           hw_code_upd          = hw_code_ff;
         endcase
      end
   end

   assign len_ok = (hw_len_upd <= MAX_ADDR_LEN) && (proto_len_upd <= MAX_ADDR_LEN);

   // Segment boundaries, measured from the first byte after the header.
   assign off = count_ff - COUNT_W'(HDR_LEN);
   assign h   = COUNT_W'(hw_len_upd);
   assign p   = COUNT_W'(proto_len_upd);
   assign b2  = h + p;
   assign b3  = b2 + h;
   assign b4  = b3 + p;

   always_comb begin
      seg      = SEG_SENDER_HW;
      idx_full = off;
      priority if (off < h) begin
         seg      = SEG_SENDER_HW;
         idx_full = off;
      end else if (off < b2) begin
         seg      = SEG_SENDER_PROTO;
         idx_full = off - h;
      end else if (off < b3) begin
         seg      = SEG_TARGET_HW;
         idx_full = off - b2;
      end else begin
         seg      = SEG_TARGET_PROTO;
         idx_full = off - b3;
      end
   end

   assign in_addr = !in_header && len_ok && (off < b4);

   // A short header is truncated; else lengths are judged before truncation.
   assign total = {1'b0, count_ff} + (COUNT_W+1)'(1);
   always_comb begin
      priority if (total < (COUNT_W+1)'(HDR_LEN)) begin
         status = STATUS_TRUNCATED;
      end else if (!len_ok) begin
         status = STATUS_BAD_LEN;
      end else if ((total - (COUNT_W+1)'(HDR_LEN)) < {1'b0, b4}) begin
         status = STATUS_TRUNCATED;
      end else begin
         status = STATUS_OK;
      end
   end

   assign emit.addr    = item_valid && in_addr;
   assign emit.summary = item_valid && item.last_byte;

   always_comb begin
      addr_rsp            = '0;
      addr_rsp.kind       = KIND_ADDR;
      addr_rsp.segment    = seg;
      addr_rsp.byte_index = idx_full[3:0];
      addr_rsp.byte_value = item.data_byte;

      sum_rsp              = '0;
      sum_rsp.kind         = KIND_SUMMARY;
      sum_rsp.hw_code      = hw_code_upd;
      sum_rsp.proto_code   = proto_code_upd;
      sum_rsp.hw_length    = hw_len_upd;
      sum_rsp.proto_length = proto_len_upd;
      sum_rsp.op_code      = opcode_upd;
      sum_rsp.status       = status;
   end

   // State advances only when the request leaves the input register.
   always_comb begin
      count_in      = count_ff;
      hw_code_in    = hw_code_ff;
      proto_code_in = proto_code_ff;
      hw_len_in     = hw_len_ff;
      proto_len_in  = proto_len_ff;
      opcode_in     = opcode_ff;
      if (commit) begin
         if (item.last_byte) begin
            count_in      = '0;
            hw_code_in    = '0;
            proto_code_in = '0;
            hw_len_in     = '0;
            proto_len_in  = '0;
            opcode_in     = '0;
         end else begin
            count_in      = (count_ff != COUNT_MAX) ? count_ff + COUNT_W'(1) : count_ff;
            hw_code_in    = hw_code_upd;
            proto_code_in = proto_code_upd;
            hw_len_in     = hw_len_upd;
            proto_len_in  = proto_len_upd;
            opcode_in     = opcode_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         hw_code_ff    <= '0;
         proto_code_ff <= '0;
         hw_len_ff     <= '0;
         proto_len_ff  <= '0;
         opcode_ff     <= '0;
      end else begin
         count_ff      <= count_in;
         hw_code_ff    <= hw_code_in;
         proto_code_ff <= proto_code_in;
         hw_len_ff     <= hw_len_in;
         proto_len_ff  <= proto_len_in;
         opcode_ff     <= opcode_in;
      end
   end

`ifndef ASSERT_OFF
   a_addr_after_header: assert property (@(posedge clock) disable iff (reset)
      emit.addr |-> (count_ff >= COUNT_W'(HDR_LEN)))
      else $error("address byte emitted inside the header");

   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      (commit && item.last_byte) |=> (count_ff == '0 && hw_len_ff == '0))
      else $error("state not cleared after the last byte");
`endif

endmodule

>>> design/arp_rsp_buf.sv
// Two-entry response buffer for the ARP parser. Takes zero, one or two
// responses per cycle and presents them in order. Depends on arp_pkg.
`timescale 1ns / 1ps

module arp_rsp_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  arp_pkg::arp_emit_type emit,
   input  arp_pkg::arp_rsp_type  addr_rsp,
   input  arp_pkg::arp_rsp_type  sum_rsp,
   output logic [1:0]            space,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output arp_pkg::arp_rsp_type  rsp_data
);
   import arp_pkg::*;

   logic [1:0]  occ_ff, occ_in;
   arp_rsp_type q0_ff, q0_in, q1_ff, q1_in;
   logic        pop;
   logic [1:0]  rem, n, push_n;
   arp_rsp_type first_rsp;

   assign rsp_valid = (occ_ff != 2'd0);
   assign rsp_data  = q0_ff;
   assign pop       = rsp_valid && rsp_ready;
   assign rem       = occ_ff - {1'b0, pop};
   assign space     = 2'd2 - rem;

   assign n         = {1'b0, emit.addr} + {1'b0, emit.summary};
   assign push_n    = push ? n : 2'd0;
   assign first_rsp = emit.addr ? addr_rsp : sum_rsp;
   assign occ_in    = rem + push_n;

   always_comb begin
      q0_in = q0_ff;
      q1_in = q1_ff;
      unique case (rem)
         2'd0: begin
            q0_in = first_rsp;
            q1_in = sum_rsp;
         end
         2'd1: begin
            q0_in = pop ? q1_ff : q0_ff;
            q1_in = first_rsp;
         end
         default: begin
            q0_in = q0_ff;
            q1_in = q1_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (push_n <= space))
      else $error("response buffer overflow");
`endif

endmodule

>>> design/arp_packet_parser_unit.sv
// Top level of the ARP header parser: input register, field decode and
// response buffer. Depends on arp_pkg, arp_field_decode and arp_rsp_buf.
`timescale 1ns / 1ps
// Path: a request accepted into the input register is decoded there and, once the
//   buffer has room, its responses are registered in the buffer until they are taken.
// Throughput: one byte per cycle; the two-entry buffer takes both responses of a
//   final address byte, and the input stalls only while the buffer lacks room.
// Reset: synchronous and active high; clears the byte counter, the header
//   registers, the input register's valid flag and the buffer occupancy.

module arp_packet_parser_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  arp_pkg::arp_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output arp_pkg::arp_rsp_type rsp_data
);
   import arp_pkg::*;

   // Input register: one request waits here while it is decoded.
   logic          s1_valid_ff, s1_valid_in;
   arp_req_type   s1_req_ff, s1_req_in;
   logic          req_fire;
   logic          advance;

   arp_emit_type  emit;
   arp_rsp_type   addr_rsp, sum_rsp;
   logic [1:0]    space;
   logic [1:0]    need;

   // A request moves on once the buffer has room for every response it makes.
   assign need      = {1'b0, emit.addr} + {1'b0, emit.summary};
   assign advance   = s1_valid_ff && (need <= space);
   assign req_ready = !s1_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign s1_valid_in = req_fire || (s1_valid_ff && !advance);
   assign s1_req_in   = req_fire ? req_data : s1_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff <= s1_req_in;
   end

   // Counter, header registers and response formation.
   arp_field_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .item_valid (s1_valid_ff),
      .item       (s1_req_ff),
      .commit     (advance),
      .emit       (emit),
      .addr_rsp   (addr_rsp),
      .sum_rsp    (sum_rsp)
   );

   // Responses wait here so that new requests keep flowing under back-pressure.
   arp_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (advance),
      .emit      (emit),
      .addr_rsp  (addr_rsp),
      .sum_rsp   (sum_rsp),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_req_ff)))
      else $error("stalled request lost from the input register");
`endif

endmodule
